/* rtl/core/tsk_pkg.sv */
`default_nettype none
package tsk_pkg;
    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_DZERO,
        ST_CHEAD,
        ST_CEDGE,
        ST_PUSH0,
        ST_POP,
        ST_WHEAD,
        ST_WEDGE,
        ST_EMIT,
        ST_DONE
    } state_t;

    localparam int VFIELD_LIMIT = 32;
endpackage
`default_nettype wire

/* rtl/core/tsk_ram.sv */
`default_nettype none
module tsk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/core/topological_sort_kahn.sv */
// Kahn topological sort engine.
// Input channel s_axis_*: tdata = {dst_vertex[9:5], src_vertex[4:0]}, tuser = mode.
// Add-edge items (mode 0) read the source head and then link the edge, unless
// the edge is dropped; clear items (mode 2) sweep the vertex heads; mode 3 is
// dropped.
// A run item (mode 1) zeroes N degree counts, walks every list once to count
// in-degrees, tests each count for the ready stack, then pops and walks
// successors. Each list step is a read of the registered edge memory followed
// by use. The engine takes one item at a time; no new item is accepted until
// the last result of a run has been taken.
// Results leave on m_axis_*: tdata = {acyclic[5], vertex[4:0]},
// tlast = last, tuser = vertex_valid. One result per emitted vertex, held one
// slot so the final one can carry last; an empty run gives one result with
// vertex_valid 0. While m_axis_tready is low the engine holds the pending
// result and accepts nothing.
// Configuration: cfg_valid/cfg_ready writes vertex_count (6 bits), accepted
// only while idle.
// Reset (aresetn low, synchronous) clears count, edge fill and then sweeps
// the head table to null before the first item.
`default_nettype none
module topological_sort_kahn #(
    parameter int MAX_NODES = 32,
    parameter int MAX_EDGES = 256
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // src_vertex[4:0], dst_vertex[9:5]
    input  wire logic [1:0] s_axis_tuser,   // mode
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // vertex[4:0], acyclic[5]
    output logic            m_axis_tlast,   // last
    output logic            m_axis_tuser,   // vertex_valid
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [5:0] cfg_data
);
    import tsk_pkg::*;

    localparam int NW = $clog2(MAX_NODES);
    localparam int EW = $clog2(MAX_EDGES);
    localparam int LW = EW + 1;  // link with null = MAX_EDGES
    localparam int DW = LW;      // degree counts up to MAX_EDGES
    localparam int CW = NW + 1;
    localparam logic [LW-1:0] NULL_L = LW'(MAX_EDGES);

    state_t state_reg, state_next;
    logic [5:0]    vcount_reg;
    logic [LW-1:0] used_reg, used_next;
    logic [CW-1:0] idx_reg, idx_next;      // vertex scan index
    logic [CW-1:0] sp_reg, sp_next;        // stack depth
    logic [CW-1:0] cnt_reg, cnt_next;      // emitted count
    logic [LW-1:0] e_reg, e_next;          // current edge
    logic [LW-1:0] guard_reg, guard_next;
    logic [4:0]    w_reg, w_next;
    logic          cur_reg, cur_next;      // add-edge link pending in PUSH0
    logic [NW-1:0] src_reg, src_next;
    logic [4:0]    dst_reg, dst_next;
    logic [4:0]    ov_reg, ov_next;
    logic          ovld_reg, ovld_next, olast_reg, olast_next, oacy_reg, oacy_next;
    logic          hold_v_reg;
    logic [4:0]    hold_x_reg;

    // active count
    logic [CW-1:0] n_act;
    always_comb begin
        if (32'(vcount_reg) > 32'(MAX_NODES) && MAX_NODES <= VFIELD_LIMIT)
            n_act = CW'(MAX_NODES);
        else if (32'(vcount_reg) > 32'(VFIELD_LIMIT))
            n_act = CW'(VFIELD_LIMIT);
        else
            n_act = CW'(vcount_reg);
    end

    // memories
    logic          h_we;  logic [NW-1:0] h_wa, h_ra; logic [LW-1:0] h_wd, h_rd;
    logic          t_we;  logic [EW-1:0] t_wa, t_ra; logic [4:0]    t_wd, t_rd;
    logic [LW-1:0] l_wd, l_rd;
    logic          d_we;  logic [NW-1:0] d_wa, d_ra; logic [DW-1:0] d_wd, d_rd;
    logic          k_we;  logic [NW-1:0] k_wa, k_ra; logic [4:0]    k_wd, k_rd;

    tsk_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_head (.aclk, .we(h_we), .waddr(h_wa),
        .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
    tsk_ram #(.WIDTH(5), .DEPTH(MAX_EDGES)) u_tgt (.aclk, .we(t_we), .waddr(t_wa),
        .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
    tsk_ram #(.WIDTH(LW), .DEPTH(MAX_EDGES)) u_link (.aclk, .we(t_we), .waddr(t_wa),
        .wdata(l_wd), .raddr(t_ra), .rdata(l_rd));
    tsk_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_deg (.aclk, .we(d_we), .waddr(d_wa),
        .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));
    tsk_ram #(.WIDTH(5), .DEPTH(MAX_NODES)) u_stk (.aclk, .we(k_we), .waddr(k_wa),
        .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));

    logic add_ok;
    logic [31:0] tgt_w;
    assign tgt_w = 32'(t_rd);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);

    // next state and datapath control
    always_comb begin
        state_next = state_reg; used_next = used_reg; idx_next = idx_reg;
        sp_next = sp_reg; cnt_next = cnt_reg; e_next = e_reg; guard_next = guard_reg;
        w_next = w_reg; cur_next = cur_reg; src_next = src_reg; dst_next = dst_reg;
        ov_next = ov_reg; ovld_next = ovld_reg; olast_next = olast_reg;
        oacy_next = oacy_reg;
        h_we = 1'b0; h_wa = idx_reg[NW-1:0]; h_wd = NULL_L; h_ra = idx_reg[NW-1:0];
        t_we = 1'b0; t_wa = used_reg[EW-1:0]; t_wd = dst_reg; l_wd = h_rd;
        t_ra = e_reg[EW-1:0];
        d_we = 1'b0; d_wa = idx_reg[NW-1:0]; d_wd = '0; d_ra = NW'(t_rd);
        k_we = 1'b0; k_wa = sp_reg[NW-1:0]; k_wd = 5'(idx_reg);
        k_ra = NW'(sp_reg - CW'(1));
        add_ok = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                src_next = NW'(s_axis_tdata[4:0]);
                dst_next = s_axis_tdata[9:5];
                h_ra = NW'(s_axis_tdata[4:0]);
                idx_next = '0;
                if (s_axis_tvalid) begin
                    unique case (mode_t'(s_axis_tuser))
                        MODE_ADD: begin
                            add_ok = (32'(s_axis_tdata[4:0]) < 32'(n_act))
                                && (32'(s_axis_tdata[9:5]) < 32'(n_act))
                                && (used_reg < NULL_L);
                            // head read returns next cycle; link in PUSH0
                            if (add_ok) state_next = ST_PUSH0;
                            cur_next = 1'b1;
                        end
                        MODE_RUN: begin
                            if (n_act == '0) begin
                                state_next = ST_EMIT; ovld_next = 1'b0;
                                olast_next = 1'b1; oacy_next = 1'b1; ov_next = '0;
                            end else state_next = ST_DZERO;
                        end
                        MODE_CLEAR: state_next = ST_CLEAR;
                        default: ;
                    endcase
                    cnt_next = '0; sp_next = '0;
                end
            end
            ST_CLEAR: begin
                h_we = 1'b1;
                idx_next = idx_reg + CW'(1);
                used_next = '0;
                if (idx_reg == CW'(MAX_NODES - 1)) state_next = ST_IDLE;
            end
            ST_DZERO: begin
                d_we = 1'b1;
                idx_next = idx_reg + CW'(1);
                if (idx_reg + CW'(1) == n_act) begin
                    idx_next = '0; state_next = ST_CHEAD;
                end
            end
            ST_CHEAD: begin
                // head of idx requested; walk on arrival
                h_ra = idx_reg[NW-1:0];
                cur_next = 1'b0; guard_next = '0; e_next = NULL_L;
                state_next = ST_CEDGE;
                cnt_next = '0;
            end
            ST_CEDGE: begin
                // cnt_reg: 0 fetch head, 1 edge requested, 2 degree requested, 3 target skipped
                unique case (cnt_reg[1:0])
                    2'd0: begin
                        e_next = h_rd; t_ra = h_rd[EW-1:0];
                        if (h_rd >= NULL_L) begin
                            idx_next = idx_reg + CW'(1);
                            if (idx_reg + CW'(1) == n_act) begin
                                state_next = ST_PUSH0; idx_next = '0;
                                cur_next = 1'b0; w_next = '0;
                            end else state_next = ST_CHEAD;
                        end else cnt_next = CW'(1);
                    end
                    2'd1: begin
                        d_ra = NW'(t_rd);
                        w_next = t_rd;
                        if (tgt_w < 32'(n_act)) cnt_next = CW'(2);
                        else cnt_next = CW'(3);
                        e_next = l_rd;
                    end
                    default: begin
                        if (cnt_reg[1:0] == 2'd2) begin
                            d_we = 1'b1; d_wa = NW'(w_reg); d_wd = d_rd + DW'(1);
                        end
                        guard_next = guard_reg + LW'(1);
                        t_ra = e_reg[EW-1:0];
                        if (e_reg >= NULL_L || guard_reg + LW'(1) >= NULL_L) begin
                            idx_next = idx_reg + CW'(1); cnt_next = '0;
                            if (idx_reg + CW'(1) == n_act) begin
                                state_next = ST_PUSH0; idx_next = '0;
                                cur_next = 1'b0; w_next = '0;
                            end else state_next = ST_CHEAD;
                        end else cnt_next = CW'(1);
                    end
                endcase
            end
            ST_PUSH0: begin
                if (cur_reg) begin
                    // add edge: head read is valid now
                    t_we = 1'b1; l_wd = h_rd;
                    h_we = 1'b1; h_wa = src_reg; h_wd = used_reg;
                    used_next = used_reg + LW'(1);
                    cur_next = 1'b0;
                    state_next = ST_IDLE;
                end else begin
                    // per vertex: read degree, then test
                    d_ra = idx_reg[NW-1:0];
                    if (!w_reg[0]) begin
                        w_next = 5'd1;
                    end else begin
                        w_next = 5'd0;
                        if (d_rd == '0) begin
                            k_we = 1'b1; sp_next = sp_reg + CW'(1);
                        end
                        idx_next = idx_reg + CW'(1);
                        if (idx_reg + CW'(1) == n_act) state_next = ST_POP;
                    end
                end
            end
            ST_POP: begin
                if (sp_reg == '0 || cnt_reg == n_act) begin
                    state_next = ST_EMIT; ovld_next = 1'b0; olast_next = 1'b1;
                    oacy_next = 1'b0; ov_next = '0;
                    if (cnt_reg != '0) state_next = ST_DONE;
                end else begin
                    sp_next = sp_reg - CW'(1);
                    state_next = ST_WHEAD;
                    guard_next = '0; e_next = '0;
                end
            end
            ST_WHEAD: begin
                // stack data valid; fetch head; e_reg used as phase here
                if (e_reg == '0) begin
                    w_next = k_rd; h_ra = NW'(k_rd);
                    e_next = LW'(1);
                end else begin
                    ov_next = w_reg; ovld_next = 1'b1; olast_next = 1'b0;
                    oacy_next = 1'b0; cnt_next = cnt_reg + CW'(1);
                    e_next = h_rd; t_ra = h_rd[EW-1:0];
                    idx_next = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // advance once the held item moves on or the hold slot is empty
                if (olast_reg) begin
                    if (m_axis_tready) state_next = ST_IDLE;
                end else if (m_axis_tready || !hold_v_reg) begin
                    if (e_reg >= NULL_L) state_next = ST_POP;
                    else begin state_next = ST_WEDGE; idx_next = '0; end
                end
            end
            ST_WEDGE: begin
                // idx phase: 0 edge fetch, 1 edge valid, 2 degree, 3 target skipped
                unique case (idx_reg[1:0])
                    2'd0: begin t_ra = e_reg[EW-1:0]; idx_next = CW'(1); end
                    2'd1: begin
                        d_ra = NW'(t_rd); src_next = NW'(t_rd);
                        e_next = l_rd;
                        idx_next = (tgt_w < 32'(n_act)) ? CW'(2) : CW'(3);
                    end
                    default: begin
                        if (idx_reg[1:0] == 2'd2 && d_rd != '0) begin
                            d_we = 1'b1; d_wa = src_reg; d_wd = d_rd - DW'(1);
                            if (d_rd == DW'(1) && sp_reg < CW'(MAX_NODES)) begin
                                k_we = 1'b1; k_wd = 5'(src_reg);
                                sp_next = sp_reg + CW'(1);
                            end
                        end
                        guard_next = guard_reg + LW'(1);
                        idx_next = '0;
                        if (e_reg >= NULL_L || guard_reg + LW'(1) >= NULL_L)
                            state_next = ST_POP;
                    end
                endcase
            end
            ST_DONE: begin
                // hold the final item until it is taken
                if (m_axis_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            vcount_reg <= '0;
            used_reg <= '0;
            idx_reg <= '0;
            sp_reg <= '0;
            cnt_reg <= '0;
            cur_reg <= 1'b0;
            w_reg <= '0;
        end else begin
            state_reg <= state_next;
            used_reg <= used_next;
            idx_reg <= idx_next;
            sp_reg <= sp_next;
            cnt_reg <= cnt_next;
            cur_reg <= cur_next;
            w_reg <= w_next;
            if (cfg_valid && cfg_ready) vcount_reg <= cfg_data;
        end
        e_reg <= e_next; guard_reg <= guard_next;
        src_reg <= src_next; dst_reg <= dst_next;
        ov_reg <= ov_next; ovld_reg <= ovld_next;
        olast_reg <= olast_next; oacy_reg <= oacy_next;
    end

    // hold each vertex result one slot so the final one can carry last
    logic          out_v;
    logic          is_new;
    assign is_new = (state_reg == ST_EMIT) && ovld_reg;
    always_comb begin
        out_v = 1'b0;
        m_axis_tdata = {3'b0, hold_x_reg};
        m_axis_tlast = 1'b0;
        m_axis_tuser = 1'b1;
        if (state_reg == ST_EMIT && !ovld_reg) begin
            out_v = 1'b1;
            m_axis_tdata = {2'b0, oacy_reg, 5'd0};
            m_axis_tlast = 1'b1;
            m_axis_tuser = 1'b0;
        end else if (is_new) begin
            out_v = hold_v_reg;
        end else if (state_reg == ST_DONE) begin
            out_v = hold_v_reg;
            m_axis_tlast = 1'b1;
            m_axis_tdata = {2'b0, (cnt_reg == n_act), hold_x_reg};
        end
    end
    assign m_axis_tvalid = out_v;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_v_reg <= 1'b0;
        end else if (is_new && (m_axis_tready || !hold_v_reg)) begin
            hold_v_reg <= 1'b1;
            hold_x_reg <= ov_reg;
        end else if (state_reg == ST_DONE && m_axis_tready) begin
            hold_v_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

/* rtl/core/tsk_checker.sv */
`default_nettype none
module tsk_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast,
    input wire logic       m_axis_tuser
);
    // an invalid-vertex result always ends a run
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("empty result without last");
    // acyclic flag only on the last result
    a_acy_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tlast |-> !m_axis_tdata[5])
        else $error("acyclic set before last");
    // no input taken while a result is offered
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted during output");
    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped");
endmodule

bind topological_sort_kahn tsk_checker u_tsk_checker (.*);
`default_nettype wire
